/* src/ism_pkg.sv */
// ----------------------------------------------------------------------------
// ism_pkg
// Shared types, defaults and the span ordering function of the
// interval sort-and-merge block.
// ----------------------------------------------------------------------------
package ism_pkg;

	localparam int unsigned MAX_SPANS_DEF = 64;
	localparam int unsigned TS_W = 64;

	typedef struct packed {
		logic [TS_W-1:0] b;
		logic [TS_W-1:0] e;
	} span_t;

	// True when span a sorts strictly before span b: by begin, then by end.
	function automatic logic span_before(input span_t a, input span_t b);
		logic res;
		if ($signed(a.b) < $signed(b.b)) begin
			res = 1'b1;
		end else if ($signed(b.b) < $signed(a.b)) begin
			res = 1'b0;
		end else begin
			res = $signed(a.e) < $signed(b.e);
		end
		return res;
	endfunction

endpackage

/* src/ism_store.sv */
// ----------------------------------------------------------------------------
// ism_store
// Span memory: one write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module ism_store #(
	parameter int unsigned DEPTH = ism_pkg::MAX_SPANS_DEF,
	parameter int unsigned AW = $clog2(DEPTH)
) (
	input  logic           clk,
	input  logic           we,
	input  logic [AW-1:0]  waddr,
	input  ism_pkg::span_t wdata,
	input  logic [AW-1:0]  raddr,
	output ism_pkg::span_t rdata
);

	ism_pkg::span_t mem [DEPTH];
	ism_pkg::span_t rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

/* src/ism_seq.sv */
// ----------------------------------------------------------------------------
// ism_seq
// Sequencer of the block: sorted insertion into the span memory, the merge
// walk over the stored spans, and the result register.
// ----------------------------------------------------------------------------
module ism_seq #(
	parameter int unsigned MAX_SPANS = ism_pkg::MAX_SPANS_DEF,
	parameter int unsigned AW = $clog2(MAX_SPANS),
	parameter int unsigned CW = $clog2(MAX_SPANS + 1)
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic signed [63:0]     span_begin,
	input  logic signed [63:0]     span_end,
	input  logic                   last_span,
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic signed [63:0]     merged_begin,
	output logic signed [63:0]     merged_end,
	output logic                   final_merged,
	output logic                   overflowed,
	output logic                   mem_we,
	output logic [AW-1:0]          mem_waddr,
	output ism_pkg::span_t         mem_wdata,
	output logic [AW-1:0]          mem_raddr,
	input  ism_pkg::span_t         mem_rdata
);

	typedef enum logic [6:0] {
		S_IDLE   = 7'b0000001,
		S_INS    = 7'b0000010,
		S_PUT    = 7'b0000100,
		S_MRD    = 7'b0001000,
		S_MFIRST = 7'b0010000,
		S_MNEXT  = 7'b0100000,
		S_MFIN   = 7'b1000000
	} state_t;

	state_t         state_q, state_d;
	logic [CW-1:0]  count_q;
	logic           ovf_q;
	logic           last_q;
	logic [AW-1:0]  pos_q;
	logic [AW-1:0]  idx_q;
	ism_pkg::span_t new_q;
	ism_pkg::span_t cur_q;
	logic           out_valid_q;
	ism_pkg::span_t out_span_q;
	logic           out_fin_q;
	logic           out_ovf_q;

	logic           in_xfer;
	logic           full;
	logic           out_free;
	logic           new_first;
	logic           overlap;
	logic           step;
	logic           at_last;
	logic           emit;
	logic           emit_fin;
	ism_pkg::span_t emit_span;
	ism_pkg::span_t in_span;

	assign in_span.b = span_begin;
	assign in_span.e = span_end;
	assign in_ready = (state_q == S_IDLE);
	assign in_xfer = in_valid && in_ready;
	assign full = (count_q == CW'(MAX_SPANS));
	assign out_free = !out_valid_q || out_ready;
	assign new_first = ism_pkg::span_before(new_q, mem_rdata);
	assign overlap = !($signed(cur_q.e) < $signed(mem_rdata.b));
	assign step = overlap || out_free;
	assign at_last = (CW'(idx_q) == count_q - CW'(1));

	always_comb begin
		state_d = state_q;
		mem_we = 1'b0;
		mem_waddr = pos_q;
		mem_wdata = new_q;
		mem_raddr = idx_q;
		emit = 1'b0;
		emit_fin = 1'b0;
		emit_span = cur_q;
		unique case (state_q)
			S_IDLE: begin
				mem_raddr = AW'(count_q - CW'(1));
				if (in_xfer) begin
					if (full) begin
						state_d = last_span ? S_MRD : S_IDLE;
					end else if (count_q == '0) begin
						state_d = S_PUT;
					end else begin
						state_d = S_INS;
					end
				end
			end
			S_INS: begin
				mem_raddr = pos_q - AW'(2);
				mem_we = 1'b1;
				if (new_first) begin
					mem_wdata = mem_rdata;
					if (pos_q == AW'(1)) begin
						state_d = S_PUT;
					end
				end else begin
					state_d = last_q ? S_MRD : S_IDLE;
				end
			end
			S_PUT: begin
				mem_we = 1'b1;
				state_d = last_q ? S_MRD : S_IDLE;
			end
			S_MRD: begin
				mem_raddr = '0;
				state_d = S_MFIRST;
			end
			S_MFIRST: begin
				mem_raddr = AW'(1);
				state_d = (count_q == CW'(1)) ? S_MFIN : S_MNEXT;
			end
			S_MNEXT: begin
				mem_raddr = step ? idx_q + AW'(1) : idx_q;
				if (!overlap && out_free) begin
					emit = 1'b1;
				end
				if (step && at_last) begin
					state_d = S_MFIN;
				end
			end
			S_MFIN: begin
				if (out_free) begin
					emit = 1'b1;
					emit_fin = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			ovf_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == S_IDLE && in_xfer && full) begin
				ovf_q <= 1'b1;
			end
			if ((state_q == S_INS && !new_first) || state_q == S_PUT) begin
				count_q <= count_q + CW'(1);
			end
			if (emit_fin) begin
				count_q <= '0;
				ovf_q <= 1'b0;
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && in_xfer) begin
			new_q <= in_span;
			last_q <= last_span;
			pos_q <= AW'(count_q);
		end
		if (state_q == S_INS && new_first) begin
			pos_q <= pos_q - AW'(1);
		end
		if (state_q == S_MFIRST) begin
			cur_q <= mem_rdata;
			idx_q <= AW'(1);
		end
		if (state_q == S_MRD) begin
			idx_q <= '0;
		end
		if (state_q == S_MNEXT && step) begin
			if (overlap) begin
				if ($signed(cur_q.e) < $signed(mem_rdata.e)) begin
					cur_q.e <= mem_rdata.e;
				end
			end else begin
				cur_q <= mem_rdata;
			end
			idx_q <= idx_q + AW'(1);
		end
		if (emit) begin
			out_span_q <= emit_span;
			out_fin_q <= emit_fin;
			out_ovf_q <= ovf_q;
		end
	end

	assign out_valid = out_valid_q;
	assign merged_begin = out_span_q.b;
	assign merged_end = out_span_q.e;
	assign final_merged = out_fin_q;
	assign overflowed = out_ovf_q;

endmodule

/* src/interval_sort_merge_top.sv */
// ----------------------------------------------------------------------------
// interval_sort_merge_top
// Loads a set of signed 64-bit inclusive spans, keeps them sorted by begin
// and end, and on the last span emits the merged spans in ascending order.
// ----------------------------------------------------------------------------
// Spans are kept in one memory of MAX_SPANS entries with a single read port,
// and that port sets the timing. Taking in a span shifts every stored span
// that sorts after it up by one entry and then writes the new span into the
// gap; a span arriving at a full store is dropped and marks the set as
// overflowed. After the last span the merge walk reads the stored spans in
// order and pauses while a finished result waits for out_ready. Results
// leave through a register, so one result may still be waiting while the
// next set starts loading. Store contents need no clearing after reset.
module interval_sort_merge_top #(
	parameter int unsigned MAX_SPANS = ism_pkg::MAX_SPANS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic signed [63:0] span_begin,
	input  logic signed [63:0] span_end,
	input  logic               last_span,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [63:0] merged_begin,
	output logic signed [63:0] merged_end,
	output logic               final_merged,
	output logic               overflowed
);

	localparam int unsigned AW = $clog2(MAX_SPANS);
	localparam int unsigned CW = $clog2(MAX_SPANS + 1);

	logic           mem_we;
	logic [AW-1:0]  mem_waddr;
	ism_pkg::span_t mem_wdata;
	logic [AW-1:0]  mem_raddr;
	ism_pkg::span_t mem_rdata;

	ism_seq #(
		.MAX_SPANS(MAX_SPANS),
		.AW(AW),
		.CW(CW)
	) u_seq (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.span_begin(span_begin),
		.span_end(span_end),
		.last_span(last_span),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.merged_begin(merged_begin),
		.merged_end(merged_end),
		.final_merged(final_merged),
		.overflowed(overflowed),
		.mem_we(mem_we),
		.mem_waddr(mem_waddr),
		.mem_wdata(mem_wdata),
		.mem_raddr(mem_raddr),
		.mem_rdata(mem_rdata)
	);

	ism_store #(
		.DEPTH(MAX_SPANS),
		.AW(AW)
	) u_store (
		.clk(clk),
		.we(mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.raddr(mem_raddr),
		.rdata(mem_rdata)
	);

endmodule

/* src/ism_checker.sv */
// ----------------------------------------------------------------------------
// ism_checker
// Port-level checks of the interval sort-and-merge block, bound to the top.
// ----------------------------------------------------------------------------
module ism_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_ready,
	input logic               last_span,
	input logic               out_valid,
	input logic               out_ready,
	input logic signed [63:0] merged_begin,
	input logic signed [63:0] merged_end,
	input logic               final_merged,
	input logic               overflowed
);

	logic have_prev_q;
	logic prev_ovf_q;

	// Tracks the overflow mark of the previous result of the open set.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			have_prev_q <= 1'b0;
			prev_ovf_q <= 1'b0;
		end else if (out_valid && out_ready) begin
			have_prev_q <= !final_merged;
			prev_ovf_q <= overflowed;
		end
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(merged_begin)
			&& $stable(merged_end) && $stable(final_merged) && $stable(overflowed))
		else $error("result changed while stalled");

	a_no_result_mid_set: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && !last_span |=> !$rose(out_valid))
		else $error("result appeared after a span that was not last");

	a_busy_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && last_span |=> !in_ready)
		else $error("input taken right after the last span");

	a_busy_mid_merge: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !final_merged |-> !in_ready)
		else $error("input open while a merge is still running");

	a_ovf_consistent: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && have_prev_q |-> overflowed == prev_ovf_q)
		else $error("overflow mark differs within one set");

endmodule

bind interval_sort_merge_top ism_checker u_ism_checker (
	.clk(clk),
	.arst_n(arst_n),
	.in_valid(in_valid),
	.in_ready(in_ready),
	.last_span(last_span),
	.out_valid(out_valid),
	.out_ready(out_ready),
	.merged_begin(merged_begin),
	.merged_end(merged_end),
	.final_merged(final_merged),
	.overflowed(overflowed)
);

/* tb/interval_sort_merge_top_test.sv */
// ----------------------------------------------------------------------------
// interval_sort_merge_top_test
// Self-checking bench for the span sort-and-merge block. Sets of spans are
// sent under several sender and receiver idling patterns. A scoreboard keeps
// its own sorted copy of each set and predicts the merged spans. Each merged
// span that leaves the block is checked field by field against the oldest
// prediction.
// ----------------------------------------------------------------------------

typedef struct {
	logic [63:0] b;
	logic [63:0] e;
	logic        fin;
	logic        ovf;
} merged_span_t;

class span_merge_board;
	ism_pkg::span_t held[$];
	bit             dropped;
	merged_span_t   awaited[$];
	int             mismatches;

	function bit sorts_first(ism_pkg::span_t x, ism_pkg::span_t y);
		return ($signed(x.b) < $signed(y.b)) ||
			(x.b == y.b && $signed(x.e) < $signed(y.e));
	endfunction

	function void push_merged(ism_pkg::span_t s, logic fin);
		merged_span_t m;
		m.b = s.b;
		m.e = s.e;
		m.fin = fin;
		m.ovf = dropped;
		awaited.insert(awaited.size(), m);
	endfunction

	function void note_span(logic [63:0] b, logic [63:0] e, logic last);
		ism_pkg::span_t s;
		ism_pkg::span_t cur;
		int pos;
		s.b = b;
		s.e = e;
		if (held.size() >= ism_pkg::MAX_SPANS_DEF) begin
			dropped = 1'b1;
		end else begin
			pos = held.size();
			while (pos > 0 && sorts_first(s, held[pos-1])) begin
				pos--;
			end
			held.insert(pos, s);
		end
		if (last) begin
			if (held.size() != 0) begin
				cur = held[0];
				for (int i = 1; i < held.size(); i++) begin
					if (!($signed(cur.e) < $signed(held[i].b))) begin
						if ($signed(cur.e) < $signed(held[i].e)) begin
							cur.e = held[i].e;
						end
					end else begin
						push_merged(cur, 1'b0);
						cur = held[i];
					end
				end
				push_merged(cur, 1'b1);
			end
			held.delete();
			dropped = 1'b0;
		end
	endfunction

	function void check_merged(logic [63:0] b, logic [63:0] e, logic fin, logic ovf);
		merged_span_t m;
		if (awaited.size() == 0) begin
			mismatches++;
			if (mismatches <= 10) begin
				$display("unexpected merged span [%0d, %0d] fin %b ovf %b",
					$signed(b), $signed(e), fin, ovf);
			end
			return;
		end
		m = awaited.pop_front();
		if (m.b !== b || m.e !== e || m.fin !== fin || m.ovf !== ovf) begin
			mismatches++;
			if (mismatches <= 10) begin
				$display("mismatch: exp [%0d, %0d] fin %b ovf %b, got [%0d, %0d] fin %b ovf %b",
					$signed(m.b), $signed(m.e), m.fin, m.ovf,
					$signed(b), $signed(e), fin, ovf);
			end
		end
	endfunction

	function int pending();
		return awaited.size();
	endfunction
endclass

module interval_sort_merge_top_test;

	localparam int unsigned CAP = ism_pkg::MAX_SPANS_DEF;
	localparam int HOLD_CYCLES = 300;
	localparam int STUCK_LIMIT = 4000;
	localparam logic signed [63:0] TS_MIN = 64'sh8000_0000_0000_0000;
	localparam logic signed [63:0] TS_MAX = 64'sh7fff_ffff_ffff_ffff;

	logic clk = 1'b0;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	logic signed [63:0] span_begin;
	logic signed [63:0] span_end;
	logic last_span;
	logic out_valid;
	logic out_ready = 1'b0;
	logic signed [63:0] merged_begin;
	logic signed [63:0] merged_end;
	logic final_merged;
	logic overflowed;

	span_merge_board board = new();
	int idle_pct = 0;
	int stall_pct = 0;
	logic hold_go = 1'b0;
	logic hold_seen = 1'b0;
	int hold_left = 0;
	int stuck_cycles = 0;

	interval_sort_merge_top #(.MAX_SPANS(CAP)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.span_begin(span_begin),
		.span_end(span_end),
		.last_span(last_span),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.merged_begin(merged_begin),
		.merged_end(merged_end),
		.final_merged(final_merged),
		.overflowed(overflowed)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// The receiver either follows its stall rate or sits out a long hold.
	always @(posedge clk) begin
		if (hold_go != hold_seen) begin
			hold_seen = hold_go;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(0, 99) >= stall_pct);
		end
	end

	// Signals are stable at the falling edge, so each transfer is seen here
	// before the rising edge that completes it.
	always @(negedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready) begin
				board.check_merged(merged_begin, merged_end, final_merged, overflowed);
			end
			if ((in_valid && in_ready) || (out_valid && out_ready)) begin
				stuck_cycles = 0;
			end else begin
				stuck_cycles++;
			end
			if (stuck_cycles >= STUCK_LIMIT) begin
				$display("[FAIL] regression broken");
				$finish;
			end
		end
	end

	task automatic send_span(logic signed [63:0] b, logic signed [63:0] e, logic last);
		logic took;
		while ($urandom_range(0, 99) < idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		span_begin <= b;
		span_end <= e;
		last_span <= last;
		took = 1'b0;
		while (!took) begin
			@(negedge clk);
			took = in_ready;
			@(posedge clk);
		end
		board.note_span(b, e, last);
	endtask

	function automatic logic signed [63:0] pick_ts(logic signed [63:0] centre);
		int r;
		r = $urandom_range(0, 19);
		if (r == 0) begin
			case ($urandom_range(0, 3))
				0: return TS_MIN;
				1: return TS_MAX;
				2: return 64'sd0;
				default: return -64'sd1;
			endcase
		end else if (r < 3) begin
			return {$urandom, $urandom};
		end
		return centre + 64'($urandom_range(0, 300)) - 64'sd150;
	endfunction

	task automatic send_random_set(int count);
		logic signed [63:0] centre;
		logic signed [63:0] b;
		logic signed [63:0] e;
		case ($urandom_range(0, 5))
			0: centre = {$urandom, $urandom};
			1: centre = TS_MAX - 64'sd100;
			2: centre = TS_MIN + 64'sd100;
			default: centre = 64'sd0;
		endcase
		for (int i = 0; i < count; i++) begin
			b = pick_ts(centre);
			if ($urandom_range(0, 9) == 0) begin
				e = pick_ts(centre);
			end else begin
				e = b + 64'($urandom_range(0, 40));
			end
			send_span(b, e, i == count - 1);
		end
	endtask

	task automatic send_small_sets(int budget);
		int sent;
		int count;
		sent = 0;
		while (sent < budget) begin
			count = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 20) : $urandom_range(1, 8);
			send_random_set(count);
			sent += count;
		end
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		span_begin = '0;
		span_end = '0;
		last_span = 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_span(TS_MIN, TS_MAX, 1'b1);

		send_span(TS_MAX, TS_MIN, 1'b0);
		send_span(64'sd0, 64'sd0, 1'b0);
		send_span(TS_MIN, TS_MIN, 1'b0);
		send_span(TS_MAX, TS_MAX, 1'b1);

		send_span(64'sd5, 64'sd10, 1'b0);
		send_span(64'sd5, 64'sd10, 1'b0);
		send_span(64'sd5, 64'sd10, 1'b1);

		send_span(64'sd1, 64'sd5, 1'b0);
		send_span(64'sd5, 64'sd8, 1'b0);
		send_span(64'sd9, 64'sd12, 1'b0);
		send_span(64'sd20, 64'sd15, 1'b0);
		send_span(64'sd13, 64'sd13, 1'b1);

		send_span(64'sd0, 64'sd100, 1'b0);
		send_span(64'sd10, 64'sd20, 1'b0);
		send_span(-64'sd5, -64'sd1, 1'b1);

		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin idle_pct = 0; stall_pct <= 0; end
				1: begin idle_pct = 84; stall_pct <= 0; end
				2: begin idle_pct = 0; stall_pct <= 84; end
				default: begin idle_pct = 29; stall_pct <= 29; end
			endcase
			send_small_sets(30);
			if (phase == 1) begin
				send_random_set(CAP);
			end
			if (phase == 3) begin
				send_random_set(CAP + 2);
			end
		end

		// Long receiver hold while spans keep coming, so the block backs up.
		idle_pct = 0;
		stall_pct <= 0;
		hold_go <= ~hold_go;
		for (int i = 0; i < 5; i++) begin
			send_random_set(3);
		end

		in_valid <= 1'b0;
		while (board.pending() != 0) begin
			@(posedge clk);
		end
		repeat (CAP + 10) @(posedge clk);
		if (board.mismatches == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule

/* files.f */
src/ism_pkg.sv
src/ism_store.sv
src/ism_seq.sv
src/interval_sort_merge_top.sv
src/ism_checker.sv
tb/interval_sort_merge_top_test.sv
